>>> design/ddrm_pkg.sv
// shared constants, types and codes of the descriptor ring manager
package ddrm_pkg;

  localparam int RING_DEPTH = 64;
  localparam int CHUNK_LOG2 = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = 40;
  localparam int LEN_W      = 32;
  localparam int ID_W       = 32;
  localparam int NEED_W     = LEN_W + 1 - CHUNK_LOG2;

  typedef enum logic [2:0] {
    KIND_DESC     = 3'd0,
    KIND_COMP     = 3'd1,
    KIND_SIZE_ERR = 3'd2,
    KIND_NO_SPACE = 3'd3,
    KIND_IDLE     = 3'd4,
    KIND_OK       = 3'd5
  } kind_e;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [LEN_W-1:0]  byte_count;
    logic [ID_W-1:0]   req_id;
    logic [IDX_W-1:0]  hw_tail;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] desc_src;
    logic [ADDR_W-1:0] desc_dst;
    logic [LEN_W-1:0]  desc_length;
    logic              first_of_request;
    logic              last_of_request;
    logic [ID_W-1:0]   done_id;
    logic [IDX_W-1:0]  new_head;
    logic              run_end;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  head_upd;
    logic  emit_desc;
    logic  emit_single;
    logic  walk_init;
    logic  rd_en;
    logic  walk_proc;
    logic  emit_final;
    kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op;
    logic zero_bytes;
    logic too_big;
    logic no_space;
    logic polling_off;
    logic walk_empty;
    logic chunk_last;
    logic entry_last;
    logic walk_done;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/ddrm_in_if.sv
// request channel carrying submit and tail items
interface ddrm_in_if;
  logic                valid;
  logic                ready;
  ddrm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/ddrm_out_if.sv
// result channel carrying descriptors, completions and status
interface ddrm_out_if;
  logic                valid;
  logic                ready;
  ddrm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/dma_descriptor_ring_manager.sv
// top level: config register, sequencer and datapath of the descriptor ring
// a request beat is taken only in idle, in the cycle after the previous item's last result
// submit: check, then per chunk one descriptor beat per cycle into the output register while free
// tail walk: a check, then a memory read and an update per walked entry, then the closing beat
// rejected, idle or polling-off items: a check, then one result beat; output stalls hold it
// reset: pointers to 0 or all ones, valid bits cleared at once, polling on, entry ids undefined
module dma_descriptor_ring_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddrm_in_if.sink     req_i,
  ddrm_out_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_POLLING_EN = 1'b0;

  logic                 polling_q;
  logic                 in_ready;
  ddrm_pkg::ctrl_cmd_t  cmd;
  ddrm_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLLING_EN) ? {31'b0, polling_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polling_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_POLLING_EN)) begin
      polling_q <= pwdata[0];
    end
  end

  ddrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddrm_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .polling_en_i (polling_q),
    .in_data_i    (req_i.data),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_data_o   (res_o.data)
  );

  assign req_i.ready = in_ready;

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request beat taken while previous item still at work");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !status.pend_valid)
    else $error("completion held back when sequencer is idle");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_desc || cmd.emit_single || cmd.emit_final ||
     (cmd.walk_proc && status.entry_last && status.pend_valid)) |-> status.out_free)
    else $error("result written over an untaken beat");

endmodule

>>> design/ddrm_datapath.sv
// ring pointers, entry memories, chunk splitter and result register
module ddrm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddrm_pkg::ctrl_cmd_t   cmd_i,
  output ddrm_pkg::dp_status_t  status_o,
  input  logic                  polling_en_i,
  input  ddrm_pkg::in_item_t    in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output ddrm_pkg::out_item_t   out_data_o
);

  localparam int FL_VALID = 0;
  localparam int FL_FIRST = 1;
  localparam int FL_LAST  = 2;
  localparam int FL_DONE  = 3;
  localparam logic [ddrm_pkg::LEN_W-1:0] CHUNK_BYTES =
    ddrm_pkg::LEN_W'(1) << ddrm_pkg::CHUNK_LOG2;
  localparam logic [ddrm_pkg::RING_AW:0] DEPTH_W =
    (ddrm_pkg::RING_AW+1)'(ddrm_pkg::RING_DEPTH);

  logic                          op_q;
  logic [ddrm_pkg::ADDR_W-1:0]   src_q, dst_q;
  logic [ddrm_pkg::LEN_W-1:0]    rem_q;
  logic [ddrm_pkg::ID_W-1:0]     id_q;
  logic [ddrm_pkg::RING_AW-1:0]  tail_q;
  logic [ddrm_pkg::RING_AW-1:0]  head_q, wc_q, ldi_q, e_q;
  logic                          first_q;

  logic                          pend_vld_q;
  logic [ddrm_pkg::RING_AW-1:0]  pend_idx_q;
  logic [ddrm_pkg::ID_W-1:0]     pend_id_q;

  logic                          ent_vld_q [ddrm_pkg::RING_DEPTH];
  logic [3:0]                    flags_mem [ddrm_pkg::RING_DEPTH];
  logic [ddrm_pkg::ID_W-1:0]     ids_mem   [ddrm_pkg::RING_DEPTH];
  logic                          rd_vld_q;
  logic [3:0]                    rd_flags_q;
  logic [ddrm_pkg::ID_W-1:0]     rd_id_q;

  logic                          out_valid_q;
  ddrm_pkg::out_item_t           out_q;

  logic [ddrm_pkg::LEN_W:0]      round_up;
  logic [ddrm_pkg::NEED_W-1:0]   needed;
  logic [ddrm_pkg::RING_AW-1:0]  p_idx, wc_next;
  logic [ddrm_pkg::RING_AW:0]    free_space;
  logic [ddrm_pkg::LEN_W-1:0]    chunk_len;
  logic                          chunk_last, entry_last, out_free;

  logic                          mem_we, ids_we;
  logic [ddrm_pkg::RING_AW-1:0]  mem_waddr;
  logic [3:0]                    mem_wflags;

  logic                          emit;
  ddrm_pkg::out_item_t           res;

  assign round_up = {1'b0, rem_q} + (ddrm_pkg::LEN_W+1)'(CHUNK_BYTES - 1'b1);
  assign needed   = round_up[ddrm_pkg::LEN_W:ddrm_pkg::CHUNK_LOG2];
  assign p_idx    = ldi_q + 1'b1;
  assign wc_next  = wc_q + 1'b1;

  always_comb begin
    if (head_q > p_idx) begin
      free_space = DEPTH_W + {1'b0, p_idx} - {1'b0, head_q};
    end else if (p_idx > head_q) begin
      free_space = {1'b0, p_idx} - {1'b0, head_q};
    end else begin
      free_space = DEPTH_W - 1'b1;
    end
  end

  assign chunk_last = (rem_q <= CHUNK_BYTES);
  assign chunk_len  = chunk_last ? rem_q : CHUNK_BYTES;
  assign entry_last = rd_vld_q && rd_flags_q[FL_LAST];
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    status_o             = '0;
    status_o.op          = op_q;
    status_o.zero_bytes  = (rem_q == '0);
    status_o.too_big     = (needed > ddrm_pkg::NEED_W'(ddrm_pkg::RING_DEPTH));
    status_o.no_space    = (needed >= ddrm_pkg::NEED_W'(free_space));
    status_o.polling_off = !polling_en_i;
    status_o.walk_empty  = (tail_q == p_idx);
    status_o.chunk_last  = chunk_last;
    status_o.entry_last  = entry_last;
    status_o.walk_done   = ((e_q + 1'b1) == tail_q);
    status_o.pend_valid  = pend_vld_q;
    status_o.out_free    = out_free;
  end

  // write port shared by descriptor writes and the done marking
  always_comb begin
    mem_we     = 1'b0;
    ids_we     = 1'b0;
    mem_waddr  = e_q;
    mem_wflags = '0;
    if (cmd_i.emit_desc) begin
      mem_we               = 1'b1;
      ids_we               = 1'b1;
      mem_waddr            = wc_next;
      mem_wflags[FL_VALID] = 1'b1;
      mem_wflags[FL_FIRST] = first_q;
      mem_wflags[FL_LAST]  = chunk_last;
    end else if (cmd_i.walk_proc) begin
      mem_we              = 1'b1;
      mem_wflags          = rd_vld_q ? rd_flags_q : 4'b0000;
      mem_wflags[FL_DONE] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flags_mem[mem_waddr] <= mem_wflags;
    end
    if (ids_we) begin
      ids_mem[mem_waddr] <= id_q;
    end
    if (cmd_i.rd_en) begin
      rd_flags_q <= flags_mem[e_q];
      rd_id_q    <= ids_mem[e_q];
    end
  end

  always_comb begin
    emit         = 1'b0;
    res          = '0;
    res.new_head = ddrm_pkg::IDX_W'(head_q);
    if (cmd_i.emit_desc) begin
      emit                 = 1'b1;
      res.kind             = ddrm_pkg::KIND_DESC;
      res.entry_index      = ddrm_pkg::IDX_W'(wc_next);
      res.desc_src         = src_q;
      res.desc_dst         = dst_q;
      res.desc_length      = chunk_len;
      res.first_of_request = first_q;
      res.last_of_request  = chunk_last;
      res.done_id          = id_q;
      res.run_end          = chunk_last;
    end else if (cmd_i.emit_single) begin
      emit        = 1'b1;
      res.kind    = cmd_i.kind;
      res.run_end = 1'b1;
    end else if (cmd_i.walk_proc && entry_last && pend_vld_q) begin
      // a newer completion exists, so the held one is not the run's end
      emit            = 1'b1;
      res.kind        = ddrm_pkg::KIND_COMP;
      res.entry_index = ddrm_pkg::IDX_W'(pend_idx_q);
      res.done_id     = pend_id_q;
    end else if (cmd_i.emit_final) begin
      emit        = 1'b1;
      res.run_end = 1'b1;
      if (pend_vld_q) begin
        res.kind        = ddrm_pkg::KIND_COMP;
        res.entry_index = ddrm_pkg::IDX_W'(pend_idx_q);
        res.done_id     = pend_id_q;
      end else begin
        res.kind = ddrm_pkg::KIND_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_data_i.op;
      src_q  <= in_data_i.src_addr;
      dst_q  <= in_data_i.dst_addr;
      rem_q  <= in_data_i.byte_count;
      id_q   <= in_data_i.req_id;
      tail_q <= in_data_i.hw_tail[ddrm_pkg::RING_AW-1:0];
    end else if (cmd_i.emit_desc) begin
      src_q <= src_q + ddrm_pkg::ADDR_W'(chunk_len);
      dst_q <= dst_q + ddrm_pkg::ADDR_W'(chunk_len);
      rem_q <= rem_q - chunk_len;
    end
    if (cmd_i.walk_proc && entry_last) begin
      pend_idx_q <= e_q;
      pend_id_q  <= rd_id_q;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      wc_q        <= '1;
      ldi_q       <= '1;
      e_q         <= '0;
      first_q     <= 1'b0;
      pend_vld_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ddrm_pkg::RING_DEPTH; i++) begin
        ent_vld_q[i] <= 1'b0;
      end
    end else begin
      if (cmd_i.capture) begin
        first_q <= 1'b1;
      end
      if (cmd_i.head_upd) begin
        head_q <= head_q + needed[ddrm_pkg::RING_AW-1:0];
      end
      if (cmd_i.emit_desc) begin
        wc_q    <= wc_next;
        first_q <= 1'b0;
      end
      if (mem_we) begin
        ent_vld_q[mem_waddr] <= 1'b1;
      end
      if (cmd_i.walk_init) begin
        e_q <= p_idx;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= ent_vld_q[e_q];
      end
      if (cmd_i.walk_proc) begin
        ldi_q <= e_q;
        e_q   <= e_q + 1'b1;
        if (entry_last) begin
          pend_vld_q <= 1'b1;
        end
      end
      if (cmd_i.emit_final) begin
        pend_vld_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/ddrm_ctrl.sv
// sequencer for submit splitting and tail walks
module ddrm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ddrm_pkg::dp_status_t  status_i,
  output ddrm_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_SINGLE,
    S_RD,
    S_PROC,
    S_FINAL
  } state_e;

  state_e          state_q, state_d;
  ddrm_pkg::kind_e kind_q, kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.op) begin
          if (status_i.polling_off) begin
            kind_d  = ddrm_pkg::KIND_OK;
            state_d = S_SINGLE;
          end else if (status_i.walk_empty) begin
            kind_d  = ddrm_pkg::KIND_IDLE;
            state_d = S_SINGLE;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = S_RD;
          end
        end else begin
          if (status_i.zero_bytes || status_i.too_big) begin
            kind_d  = ddrm_pkg::KIND_SIZE_ERR;
            state_d = S_SINGLE;
          end else if (status_i.no_space) begin
            kind_d  = ddrm_pkg::KIND_NO_SPACE;
            state_d = S_SINGLE;
          end else begin
            cmd_o.head_upd = 1'b1;
            state_d        = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_desc = 1'b1;
          if (status_i.chunk_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (status_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PROC;
      end
      S_PROC: begin
        // a held completion has to leave before a new one replaces it
        if (!(status_i.entry_last && status_i.pend_valid) || status_i.out_free) begin
          cmd_o.walk_proc = 1'b1;
          state_d         = status_i.walk_done ? S_FINAL : S_RD;
        end
      end
      S_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= ddrm_pkg::KIND_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule
